/* hdl/ddpi_pkg.sv */
// ----------------------------------------------------------------------------
// ddpi_pkg
// Shared types, widths, register codes and helpers of the differential-drive
// PI wheel speed controller.
// ----------------------------------------------------------------------------
package ddpi_pkg;

   localparam int FIELD_W  = 16;
   localparam int CSR_IDX_W = 3;

   // Fixed-point widths of the per-wheel chain, sized to the value ranges.
   localparam int TURN_W   = 17;   // Q.12 turn component
   localparam int SUM_W    = 18;   // speed -/+ turn
   localparam int TPROD_W  = 35;   // sum * inverse_radius
   localparam int TARGET_W = 31;   // Q.16 target wheel speed
   localparam int MEAS_W   = 33;   // Q.16 measured wheel speed
   localparam int ERR_W    = 34;   // Q.16 speed error
   localparam int EPROD_W  = 50;   // error * 16-bit unsigned register
   localparam int STEP_W   = 34;   // integrator increment
   localparam int INTEG_W  = 32;   // Q16.16 integrator
   localparam int ISUM_W   = 36;   // integrator plus increment, before clamp
   localparam int IPROD_W  = 48;   // integrator * integral_gain
   localparam int DRIVE_W  = 51;   // proportional plus integral term
   localparam int DRIVE_SHIFT = 24;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_PERIOD    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENCODER_SCALE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_TRACK     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_RADIUS = 3'd5;

   // Register reset values.
   localparam logic [FIELD_W-1:0] PROP_GAIN_RST      = 16'd256;
   localparam logic [FIELD_W-1:0] INTEGRAL_GAIN_RST  = 16'd1280;
   localparam logic [FIELD_W-1:0] TICK_PERIOD_RST    = 16'd6554;
   localparam logic [FIELD_W-1:0] ENCODER_SCALE_RST  = 16'd11437;
   localparam logic [FIELD_W-1:0] HALF_TRACK_RST     = 16'd7537;
   localparam logic [FIELD_W-1:0] INVERSE_RADIUS_RST = 16'd7273;

   typedef struct packed {
      logic [FIELD_W-1:0] prop_gain;
      logic [FIELD_W-1:0] integral_gain;
      logic [FIELD_W-1:0] tick_period;
      logic [FIELD_W-1:0] encoder_scale;
      logic [FIELD_W-1:0] half_track;
      logic [FIELD_W-1:0] inverse_radius;
   } cfg_type;

   // Stage load strobes from the sequencer to the wheel lanes.
   typedef struct packed {
      logic ld_target;
      logic ld_error;
      logic ld_step;
      logic ld_integ;
      logic ld_iprod;
      logic ld_drive;
   } lane_ctl_type;

   // Clamp the widened integrator sum to signed 32 bits.
   function automatic logic signed [INTEG_W-1:0] sat_integ(
      input logic signed [ISUM_W-1:0] x);
      logic signed [ISUM_W-1:0] hi;
      logic signed [ISUM_W-1:0] lo;
      hi = ISUM_W'(signed'({1'b0, {(INTEG_W-1){1'b1}}}));
      lo = -hi - ISUM_W'(1);
      if (x > hi) begin
         sat_integ = hi[INTEG_W-1:0];
      end else if (x < lo) begin
         sat_integ = lo[INTEG_W-1:0];
      end else begin
         sat_integ = x[INTEG_W-1:0];
      end
   endfunction

   // Divide by 2^24 rounding toward zero, then clamp to signed 16 bits.
   function automatic logic signed [FIELD_W-1:0] drive_to_pwm(
      input logic signed [DRIVE_W-1:0] d);
      logic signed [DRIVE_W-1:0]             adj;
      logic signed [DRIVE_W-DRIVE_SHIFT-1:0] q;
      logic signed [DRIVE_W-DRIVE_SHIFT-1:0] hi;
      logic signed [DRIVE_W-DRIVE_SHIFT-1:0] lo;
      adj = d[DRIVE_W-1] ? d + DRIVE_W'((64'd1 << DRIVE_SHIFT) - 64'd1) : d;
      q   = adj[DRIVE_W-1:DRIVE_SHIFT];
      hi  = (DRIVE_W-DRIVE_SHIFT)'(signed'({1'b0, {(FIELD_W-1){1'b1}}}));
      lo  = -hi - (DRIVE_W-DRIVE_SHIFT)'(1);
      if (q > hi) begin
         drive_to_pwm = hi[FIELD_W-1:0];
      end else if (q < lo) begin
         drive_to_pwm = lo[FIELD_W-1:0];
      end else begin
         drive_to_pwm = q[FIELD_W-1:0];
      end
   endfunction

endpackage

/* hdl/ddpi_req_if.sv */
// ----------------------------------------------------------------------------
// ddpi_req_if
// Request channel: encoder deltas and body speed command, valid/ready.
// ----------------------------------------------------------------------------
interface ddpi_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [ddpi_pkg::FIELD_W-1:0]   ticks_left;
   logic signed [ddpi_pkg::FIELD_W-1:0]   ticks_right;
   logic signed [ddpi_pkg::FIELD_W-1:0]   speed_target;
   logic signed [ddpi_pkg::FIELD_W-1:0]   turn_target;

   modport source (output valid, ticks_left, ticks_right, speed_target, turn_target,
                   input ready);
   modport sink   (input valid, ticks_left, ticks_right, speed_target, turn_target,
                   output ready);
   modport mon    (input valid, ready, ticks_left, ticks_right, speed_target,
                   turn_target);
endinterface

/* hdl/ddpi_rsp_if.sv */
// ----------------------------------------------------------------------------
// ddpi_rsp_if
// Response channel: left and right PWM drive, valid/ready.
// ----------------------------------------------------------------------------
interface ddpi_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [ddpi_pkg::FIELD_W-1:0]   duty_left;
   logic signed [ddpi_pkg::FIELD_W-1:0]   duty_right;

   modport source (output valid, duty_left, duty_right, input ready);
   modport sink   (input valid, duty_left, duty_right, output ready);
   modport mon    (input valid, ready, duty_left, duty_right);
endinterface

/* hdl/ddpi_lane.sv */
// ----------------------------------------------------------------------------
// ddpi_lane
// One wheel: target speed, measured speed, error, saturating integrator and
// the PI drive sum, one registered step per sequencer strobe.
// ----------------------------------------------------------------------------
module ddpi_lane (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ddpi_pkg::lane_ctl_type                  ctl,
   input  ddpi_pkg::cfg_type                       cfg,
   input  logic                                    turn_sub,
   input  logic signed [ddpi_pkg::FIELD_W-1:0]     speed,
   input  logic signed [ddpi_pkg::TURN_W-1:0]      turn,
   input  logic signed [ddpi_pkg::FIELD_W-1:0]     ticks,
   output logic signed [ddpi_pkg::DRIVE_W-1:0]     drive
);

   logic signed [ddpi_pkg::SUM_W-1:0]    sum;
   logic signed [ddpi_pkg::TPROD_W-1:0]  tprod;
   logic signed [ddpi_pkg::MEAS_W-1:0]   meas;
   logic signed [ddpi_pkg::EPROD_W-1:0]  sprod;
   logic signed [ddpi_pkg::EPROD_W-1:0]  pprod;
   logic signed [ddpi_pkg::ISUM_W-1:0]   isum;
   logic signed [ddpi_pkg::IPROD_W-1:0]  iprod;

   logic signed [ddpi_pkg::TARGET_W-1:0] target_ff;
   logic signed [ddpi_pkg::MEAS_W-1:0]   meas_ff;
   logic signed [ddpi_pkg::ERR_W-1:0]    error_ff;
   logic signed [ddpi_pkg::STEP_W-1:0]   step_ff;
   logic signed [ddpi_pkg::EPROD_W-1:0]  pprod_ff;
   logic signed [ddpi_pkg::INTEG_W-1:0]  integ_ff;
   logic signed [ddpi_pkg::INTEG_W-1:0]  integ_in;
   logic signed [ddpi_pkg::IPROD_W-1:0]  iprod_ff;
   logic signed [ddpi_pkg::DRIVE_W-1:0]  drive_ff;

   always_comb begin
      sum   = turn_sub ? ddpi_pkg::SUM_W'(speed) - ddpi_pkg::SUM_W'(turn)
                       : ddpi_pkg::SUM_W'(speed) + ddpi_pkg::SUM_W'(turn);
      tprod = sum * $signed({1'b0, cfg.inverse_radius});
      meas  = ticks * $signed({1'b0, cfg.encoder_scale});
      sprod = error_ff * $signed({1'b0, cfg.tick_period});
      pprod = error_ff * $signed({1'b0, cfg.prop_gain});
      isum  = ddpi_pkg::ISUM_W'(integ_ff) + ddpi_pkg::ISUM_W'(step_ff);
      iprod = integ_ff * $signed({1'b0, cfg.integral_gain});
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_target) begin
         target_ff <= tprod[ddpi_pkg::TPROD_W-1:4];
         meas_ff   <= meas;
      end
      if (ctl.ld_error) begin
         error_ff <= ddpi_pkg::ERR_W'(target_ff) - ddpi_pkg::ERR_W'(meas_ff);
      end
      if (ctl.ld_step) begin
         // floor shift: keep the upper bits
         step_ff  <= sprod[ddpi_pkg::EPROD_W-1:16];
         pprod_ff <= pprod;
      end
      if (ctl.ld_iprod) begin
         iprod_ff <= iprod;
      end
      if (ctl.ld_drive) begin
         drive_ff <= ddpi_pkg::DRIVE_W'(pprod_ff) + ddpi_pkg::DRIVE_W'(iprod_ff);
      end
   end

   assign integ_in = ctl.ld_integ ? ddpi_pkg::sat_integ(isum) : integ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else begin
         integ_ff <= integ_in;
      end
   end

   assign drive = drive_ff;

endmodule

/* hdl/ddpi_merge.sv */
// ----------------------------------------------------------------------------
// ddpi_merge
// Merge both lane drives into one response word: round, clamp and hold it
// in the output register until the sink takes it.
// ----------------------------------------------------------------------------
module ddpi_merge (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  done,
   input  logic signed [ddpi_pkg::DRIVE_W-1:0]   drive_left,
   input  logic signed [ddpi_pkg::DRIVE_W-1:0]   drive_right,
   output logic                                  load,
   ddpi_rsp_if.source                            rsp_bus
);

   logic                                 valid_ff;
   logic                                 valid_in;
   logic signed [ddpi_pkg::FIELD_W-1:0]  duty_left_ff;
   logic signed [ddpi_pkg::FIELD_W-1:0]  duty_right_ff;

   assign load     = done && (!valid_ff || rsp_bus.ready);
   assign valid_in = load || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         duty_left_ff  <= ddpi_pkg::drive_to_pwm(drive_left);
         duty_right_ff <= ddpi_pkg::drive_to_pwm(drive_right);
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.duty_left  = duty_left_ff;
   assign rsp_bus.duty_right = duty_right_ff;

endmodule

/* hdl/diff_drive_pi_wheel_control_unit.sv */
// ----------------------------------------------------------------------------
// diff_drive_pi_wheel_control_unit
// Differential-drive PI wheel speed controller, two wheel lanes in parallel.
// ----------------------------------------------------------------------------
// Each request word carries one control tick: left and right encoder deltas
// and the commanded forward speed and yaw rate (Q4.12). The unit converts the
// command into per-wheel target speeds, compares them with the measured speeds,
// updates a saturating Q16.16 integrator per wheel and answers with one
// response word of signed, clamped PWM values. Each word passes in order through
// the shared turn multiply, the six registered multiply/add steps of the wheel
// lanes (both lanes stepping in lockstep under one sequencer) and the round and
// clamp into the output register; the next word is taken only once the unit is
// back in idle. The response is held in the output register, so a stalled sink
// only delays the final step. Registers must be written through the csr_ port
// only while the unit is idle; the unit itself does not enforce this.
// Indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module diff_drive_pi_wheel_control_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   ddpi_req_if.sink                             req_bus,
   ddpi_rsp_if.source                           rsp_bus,
   input  logic                                 csr_we,
   input  logic [ddpi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ddpi_pkg::FIELD_W-1:0]         csr_wdata
);

   // Sequencer phases; each loads one register stage.
   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_TURN   = 4'd1;
   localparam logic [3:0] PH_TARGET = 4'd2;
   localparam logic [3:0] PH_ERROR  = 4'd3;
   localparam logic [3:0] PH_STEP   = 4'd4;
   localparam logic [3:0] PH_INTEG  = 4'd5;
   localparam logic [3:0] PH_IPROD  = 4'd6;
   localparam logic [3:0] PH_DRIVE  = 4'd7;
   localparam logic [3:0] PH_DONE   = 4'd8;

   logic [3:0]                            phase_ff;
   logic [3:0]                            phase_in;
   ddpi_pkg::cfg_type                     cfg_ff;
   ddpi_pkg::cfg_type                     cfg_in;
   ddpi_pkg::lane_ctl_type                ctl;

   logic                                  accept;
   logic                                  load;

   logic signed [ddpi_pkg::FIELD_W-1:0]   ticks_left_ff;
   logic signed [ddpi_pkg::FIELD_W-1:0]   ticks_right_ff;
   logic signed [ddpi_pkg::FIELD_W-1:0]   speed_ff;
   logic signed [ddpi_pkg::FIELD_W-1:0]   turn_cmd_ff;
   logic signed [ddpi_pkg::MEAS_W-1:0]    turn_prod;
   logic signed [ddpi_pkg::TURN_W-1:0]    turn_ff;

   logic signed [ddpi_pkg::DRIVE_W-1:0]   drive_left;
   logic signed [ddpi_pkg::DRIVE_W-1:0]   drive_right;

   // Take a new word only when both lanes are free.
   assign req_bus.ready = (phase_ff == PH_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   // Sequencer: step through the chain, hold in DONE until the result lands.
   always_comb begin
      case (phase_ff)
         PH_IDLE:  phase_in = accept ? PH_TURN : PH_IDLE;
         PH_TURN, PH_TARGET, PH_ERROR, PH_STEP, PH_INTEG, PH_IPROD, PH_DRIVE: begin
            phase_in = phase_ff + 4'd1;
         end
         PH_DONE:  phase_in = load ? PH_IDLE : PH_DONE;
         default:  phase_in = PH_IDLE;
      endcase
   end

   always_comb begin
      ctl.ld_target = (phase_ff == PH_TARGET);
      ctl.ld_error  = (phase_ff == PH_ERROR);
      ctl.ld_step   = (phase_ff == PH_STEP);
      ctl.ld_integ  = (phase_ff == PH_INTEG);
      ctl.ld_iprod  = (phase_ff == PH_IPROD);
      ctl.ld_drive  = (phase_ff == PH_DRIVE);
   end

   // Register file; out-of-range indexes drop the write.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            ddpi_pkg::CSR_PROP_GAIN:      cfg_in.prop_gain      = csr_wdata;
            ddpi_pkg::CSR_INTEGRAL_GAIN:  cfg_in.integral_gain  = csr_wdata;
            ddpi_pkg::CSR_TICK_PERIOD:    cfg_in.tick_period    = csr_wdata;
            ddpi_pkg::CSR_ENCODER_SCALE:  cfg_in.encoder_scale  = csr_wdata;
            ddpi_pkg::CSR_HALF_TRACK:     cfg_in.half_track     = csr_wdata;
            ddpi_pkg::CSR_INVERSE_RADIUS: cfg_in.inverse_radius = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff              <= PH_IDLE;
         cfg_ff.prop_gain      <= ddpi_pkg::PROP_GAIN_RST;
         cfg_ff.integral_gain  <= ddpi_pkg::INTEGRAL_GAIN_RST;
         cfg_ff.tick_period    <= ddpi_pkg::TICK_PERIOD_RST;
         cfg_ff.encoder_scale  <= ddpi_pkg::ENCODER_SCALE_RST;
         cfg_ff.half_track     <= ddpi_pkg::HALF_TRACK_RST;
         cfg_ff.inverse_radius <= ddpi_pkg::INVERSE_RADIUS_RST;
      end else begin
         phase_ff <= phase_in;
         cfg_ff   <= cfg_in;
      end
   end

   // Capture the request word.
   always_ff @(posedge clock) begin
      if (accept) begin
         ticks_left_ff  <= req_bus.ticks_left;
         ticks_right_ff <= req_bus.ticks_right;
         speed_ff       <= req_bus.speed_target;
         turn_cmd_ff    <= req_bus.turn_target;
      end
   end

   // Shared turn term: floor(turn_target * half_track / 2^16), Q.12.
   assign turn_prod = turn_cmd_ff * $signed({1'b0, cfg_ff.half_track});

   always_ff @(posedge clock) begin
      if (phase_ff == PH_TURN) begin
         turn_ff <= turn_prod[ddpi_pkg::MEAS_W-1:16];
      end
   end

   // Left wheel subtracts the turn term, right wheel adds it.
   ddpi_lane u_lane_left (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .cfg      (cfg_ff),
      .turn_sub (1'b1),
      .speed    (speed_ff),
      .turn     (turn_ff),
      .ticks    (ticks_left_ff),
      .drive    (drive_left)
   );

   ddpi_lane u_lane_right (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .cfg      (cfg_ff),
      .turn_sub (1'b0),
      .speed    (speed_ff),
      .turn     (turn_ff),
      .ticks    (ticks_right_ff),
      .drive    (drive_right)
   );

   ddpi_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .done        (phase_ff == PH_DONE),
      .drive_left  (drive_left),
      .drive_right (drive_right),
      .load        (load),
      .rsp_bus     (rsp_bus)
   );

endmodule

/* hdl/ddpi_checker.sv */
// ----------------------------------------------------------------------------
// ddpi_checker
// Port-level checks of the wheel controller, bound to the top level.
// ----------------------------------------------------------------------------
module ddpi_checker (
   input logic          clock,
   input logic          reset,
   ddpi_req_if.sink     req_bus,
   ddpi_rsp_if.source   rsp_bus
);

   logic req_acc;
   assign req_acc = req_bus.valid && req_bus.ready;

   // One word at a time: ready drops right after an acceptance.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_bus.ready)
      else $error("request accepted while a word is in flight");

   // No response the cycle after acceptance unless one was already waiting.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_acc && !rsp_bus.valid) |=> !rsp_bus.valid)
      else $error("response appeared too early");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> rsp_bus.valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready)
         |=> ($stable(rsp_bus.duty_left) && $stable(rsp_bus.duty_right)))
      else $error("response changed while stalled");

endmodule

bind diff_drive_pi_wheel_control_unit ddpi_checker u_ddpi_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);
